// File: hdl/caseless_phrase_match_filter_unit_macros.svh
// Assertion macros shared by the caseless phrase match filter RTL.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef CASELESS_PHRASE_MATCH_FILTER_UNIT_MACROS_SVH
`define CASELESS_PHRASE_MATCH_FILTER_UNIT_MACROS_SVH

// The expression must hold at every clock edge out of reset.
`define CPMF_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cpmf_pkg.sv
// Package of the caseless phrase match filter: sizes, types, phrase table
// and the case folding function. No dependencies.
package cpmf_pkg;

  localparam int unsigned PHRASE_COUNT   = 5;
  localparam int unsigned LONGEST_PHRASE = 25;
  localparam int unsigned WINDOW_DEPTH   = LONGEST_PHRASE - 1;
  localparam int unsigned FILL_W         = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned LEN_W          = $clog2(LONGEST_PHRASE + 1);

  typedef logic [7:0] byte_t;
  typedef logic [WINDOW_DEPTH-1:0][7:0] window_t;
  typedef logic [LONGEST_PHRASE*8-1:0] phrase_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [LEN_W-1:0] len_t;

  // Strings are right aligned: the last character of a phrase sits in byte 0.
  localparam phrase_t PHRASE_TEXT [PHRASE_COUNT] = '{
    phrase_t'("thanks for watching"),
    phrase_t'("subscribe to"),
    phrase_t'("thank you for watching"),
    phrase_t'("please like and subscribe"),
    phrase_t'("see you in the next")
  };

  localparam len_t PHRASE_CHARS [PHRASE_COUNT] = '{
    len_t'(19), len_t'(12), len_t'(22), len_t'(25), len_t'(19)
  };

  localparam byte_t UPPER_A   = 8'h41;
  localparam byte_t UPPER_Z   = 8'h5A;
  localparam byte_t CASE_STEP = 8'h20;

  function automatic byte_t fold_byte(input byte_t b);
    byte_t r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_STEP;
    end
    return r;
  endfunction

endpackage

// File: hdl/cpmf_match.sv
// Phrase comparator of the caseless phrase match filter: compares the current
// folded byte and the window against every phrase in parallel. Uses cpmf_pkg.
module cpmf_match import cpmf_pkg::*; (
  input  byte_t   cur_i,
  input  window_t window_i,
  input  fill_t   fill_i,
  output logic    hit_o
);

  always_comb begin
    logic ok;
    hit_o = 1'b0;
    for (int p = 0; p < PHRASE_COUNT; p++) begin
      ok = (fill_i >= FILL_W'(PHRASE_CHARS[p] - 1'b1));
      if (PHRASE_TEXT[p][7:0] != cur_i) begin
        ok = 1'b0;
      end
      for (int k = 1; k < LONGEST_PHRASE; k++) begin
        if (LEN_W'(k) < PHRASE_CHARS[p] && PHRASE_TEXT[p][8*k +: 8] != window_i[k-1]) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

// File: hdl/caseless_phrase_match_filter_unit.sv
// A closing item's result is written to the result register when the item leaves the input register.
// Throughput: one item per cycle unless a closing item waits; the window, fill count and match flag
// update between the input register and the result register.
// A closing item waits in the input register while an earlier result is unread.
// Reset: rst_ni is asynchronous and active low; it empties both registers and
// clears the fill count and match flag. The block is ready right after reset.
`include "caseless_phrase_match_filter_unit_macros.svh"

module caseless_phrase_match_filter_unit import cpmf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tuser_i,   // [0] has_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] is_match, [7:1] zero
);

  logic    in_valid_q;
  byte_t   in_byte_q;
  logic    in_has_q;
  logic    in_last_q;
  window_t window_q;
  fill_t   fill_q;
  logic    seen_q;
  logic    out_valid_q;
  logic    out_match_q;
  logic    advance;
  logic    hit;
  logic    seen_d;

  assign advance = in_valid_q && !(in_last_q && out_valid_q && !m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  cpmf_match u_match (
    .cur_i    (in_byte_q),
    .window_i (window_q),
    .fill_i   (fill_q),
    .hit_o    (hit)
  );

  assign seen_d = seen_q || (in_has_q && hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= fold_byte(s_axis_tdata_i);
      in_has_q  <= s_axis_tuser_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      seen_q <= 1'b0;
    end else if (advance) begin
      if (in_last_q) begin
        fill_q <= '0;
        seen_q <= 1'b0;
      end else if (in_has_q) begin
        seen_q <= seen_d;
        if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_has_q) begin
      window_q <= {window_q[WINDOW_DEPTH-2:0], in_byte_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_match_q <= seen_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, out_match_q};

  `CPMF_ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_W'(WINDOW_DEPTH), "fill count overflow")
  `CPMF_ASSERT_NEXT(a_close_clears, advance && in_last_q,
                    fill_q == '0 && !seen_q && out_valid_q, "text close did not clear state")
  `CPMF_ASSERT_NEXT(a_seen_sticky, seen_q && !(advance && in_last_q), seen_q,
                    "match flag dropped inside a text")
  `CPMF_ASSERT_ALWAYS(a_stall_blocks, !(in_valid_q && in_last_q && out_valid_q &&
                      !m_axis_tready_i) || !s_axis_tready_o, "closing item overran result")

endmodule
